>>> hdl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Check a property on the rising clock edge, disabled while reset is held.
`define SPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/spq_pkg.sv
// Package with word types, operation and status codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] in_value;
        logic [31:0] in_priority;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_value;
        logic [31:0] out_priority;
        logic [4:0]  occupancy;
    } t_out_word;

    typedef struct packed {
        logic enq;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: control, front selection and result register.
// Usage:
//   Input channel i_in_word / i_in_valid / o_in_stall carries one operation per word:
//   enqueue, dequeue or peek. Output channel o_out_word / o_out_valid / i_out_stall
//   returns one result word per operation: status, entry concerned, occupancy.
//   i_cfg_we / i_cfg_data write the max_mode bit (0 lowest first, 1 highest first).
//   Entries sit in a chain of CAPACITY cells kept sorted by ascending priority; an
//   enqueue compares in every cell at once and shifts the tail right by one cell.
//   An accepted word is captured into the operation register; the cells and the result
//   register are then updated together once the output register is free. The block
//   takes one operation at a time.
//   The result register holds while i_out_stall is high; an operation already
//   captured waits for it, and o_in_stall stays high until that operation completes.
//   Reset empties the queue, clears max_mode and drops any pending result.
//   Enqueue on a full queue and dequeue or peek on an empty one are flagged.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
    parameter int CAPACITY    = spq_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire                     i_cfg_data,
    input  wire                     i_in_valid,
    input  wire spq_pkg::t_in_word  i_in_word,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output spq_pkg::t_out_word      o_out_word,
    input  wire                     i_out_stall
);
    import spq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic                   r_max_mode;
    logic                   r_busy, n_busy;
    logic [CW-1:0]          r_count, n_count;
    t_in_word               r_op;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out, n_out;

    logic                   in_take;
    logic                   exec;
    t_cell_ctl              ctl;
    logic [VALUE_WIDTH-1:0] new_val;
    logic [VALUE_WIDTH-1:0] c_val [CAPACITY];
    logic [31:0]            c_pri [CAPACITY];
    logic                   c_gt  [CAPACITY];
    logic [VALUE_WIDTH-1:0] tail_val;
    logic [31:0]            tail_pri;
    logic [VALUE_WIDTH-1:0] front_val;
    logic [31:0]            front_pri;
    logic                   empty;
    logic                   full;

    assign in_take = i_in_valid && !o_in_stall;
    assign exec    = r_busy && (!r_out_valid || !i_out_stall);
    assign empty   = r_count == '0;
    assign full    = r_count >= FULL_COUNT;
    assign new_val = VALUE_WIDTH'(r_op.in_value);

    always_comb begin
        tail_val = '0;
        tail_pri = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CW'(k) == r_count - CW'(1)) begin
                tail_val = tail_val | c_val[k];
                tail_pri = tail_pri | c_pri[k];
            end
        end
        front_val = r_max_mode ? tail_val : c_val[0];
        front_pri = r_max_mode ? tail_pri : c_pri[0];
    end

    always_comb begin
        ctl.enq      = exec && (r_op.mode == OP_ENQ) && !full;
        ctl.shift    = exec && (r_op.mode == OP_DEQ) && !empty && !r_max_mode;
        n_count      = r_count;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        n_busy       = r_busy;
        if (exec) begin
            n_busy           = 1'b0;
            n_out_valid      = 1'b1;
            n_out.status     = ST_OK;
            n_out.out_value  = '0;
            n_out.out_priority = '0;
            case (r_op.mode)
                OP_ENQ: begin
                    if (full) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (empty) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out.out_value    = 32'(front_val);
                        n_out.out_priority = front_pri;
                        if (r_op.mode == OP_DEQ) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            n_out.occupancy = 5'(n_count);
        end
        if (in_take) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mode  <= 1'b0;
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_mode <= i_cfg_data;
            end
            r_busy      <= n_busy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (in_take) begin
            r_op <= i_in_word;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] left_val, right_val;
        logic [31:0]            left_pri, right_pri;
        logic                   left_gt;

        if (g == 0) begin : g_first
            assign left_val = '0;
            assign left_pri = '0;
            assign left_gt  = 1'b0;
        end else begin : g_mid
            assign left_val = c_val[g-1];
            assign left_pri = c_pri[g-1];
            assign left_gt  = c_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_val = '0;
            assign right_pri = '0;
        end else begin : g_inner
            assign right_val = c_val[g+1];
            assign right_pri = c_pri[g+1];
        end

        spq_cell #(
            .IDX (g),
            .CW  (CW),
            .VW  (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_count     (r_count),
            .i_new_val   (new_val),
            .i_new_pri   (r_op.in_priority),
            .i_left_val  (left_val),
            .i_left_pri  (left_pri),
            .i_left_gt   (left_gt),
            .i_right_val (right_val),
            .i_right_pri (right_pri),
            .o_val       (c_val[g]),
            .o_pri       (c_pri[g]),
            .o_gt        (c_gt[g])
        );
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`include "sorted_priority_queue_assert.svh"

    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FULL_COUNT, "occupancy above capacity")
    `SPQ_ASSERT(a_exec_frees, i_clk, i_rst_n, exec |=> !r_busy && r_out_valid, "operation did not complete")
    `SPQ_ASSERT(a_enq_count, i_clk, i_rst_n, ctl.enq |=> r_count == $past(r_count) + CW'(1), "enqueue count slip")
    `SPQ_ASSERT(a_busy_blocks, i_clk, i_rst_n, r_busy |-> !in_take, "word taken while busy")

endmodule
`default_nettype wire

>>> hdl/spq_cell.sv
// One storage cell of the sorted chain: holds an entry, inserts or shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int VW  = 32
) (
    input  wire                      i_clk,
    input  wire spq_pkg::t_cell_ctl  i_ctl,
    input  wire [CW-1:0]             i_count,
    input  wire [VW-1:0]             i_new_val,
    input  wire [31:0]               i_new_pri,
    input  wire [VW-1:0]             i_left_val,
    input  wire [31:0]               i_left_pri,
    input  wire                      i_left_gt,
    input  wire [VW-1:0]             i_right_val,
    input  wire [31:0]               i_right_pri,
    output logic [VW-1:0]            o_val,
    output logic [31:0]              o_pri,
    output logic                     o_gt
);
    import spq_pkg::*;

    localparam logic [CW-1:0] POS      = CW'(IDX);
    localparam logic [CW:0]   POS_NEXT = (CW+1)'(IDX + 1);

    logic [VW-1:0] r_val, n_val;
    logic [31:0]   r_pri, n_pri;
    logic          held;
    logic          at_end;

    always_comb begin
        held   = POS < i_count;
        at_end = POS == i_count;
        o_gt   = held && (r_pri > i_new_pri);
        n_val  = r_val;
        n_pri  = r_pri;
        if (i_ctl.enq && (o_gt || at_end)) begin
            n_val = i_left_gt ? i_left_val : i_new_val;
            n_pri = i_left_gt ? i_left_pri : i_new_pri;
        end else if (i_ctl.shift && (POS_NEXT < {1'b0, i_count})) begin
            n_val = i_right_val;
            n_pri = i_right_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_pri <= n_pri;
    end

    assign o_val = r_val;
    assign o_pri = r_pri;

endmodule
`default_nettype wire
